FILE: design/ubsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubsr_pkg
// Shared types and codes for the unordered bag with swap-remove.
// ----------------------------------------------------------------------------
package ubsr_pkg;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_MEMBER = 3'd2,
        MODE_READ   = 3'd3,
        MODE_WRITE  = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_RDATA,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        status_t            status;
        logic               found;
        logic [VALUE_W-1:0] read_value;
    } res_t;

endpackage

FILE: design/unordered_bag_swap_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unordered_bag_swap_remove
// Fixed-capacity unordered bag of signed 32-bit values with swap-remove.
// ----------------------------------------------------------------------------
// Entries live in one RAM with a single read port, which is registered;
// every request gives exactly one result. Add, write and unused modes go
// straight to the done state, and read passes through a read-data state
// first. Member and remove search the entries in a scan state, reading
// one entry per cycle through the RAM read port; remove then fetches the
// last entry and writes it into the freed slot. The result sits in an output
// register, so a new request is taken while the previous result waits.
// Requests never overlap in the RAM, so no forwarding is needed.
module unordered_bag_swap_remove #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ubsr_pkg::MODE_W-1:0]         s_mode,
    input  logic signed [ubsr_pkg::VALUE_W-1:0] s_value,
    input  logic [ubsr_pkg::IDX_W-1:0]          s_slot_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ubsr_pkg::STATUS_W-1:0]       m_status,
    output logic                                m_found,
    output logic signed [ubsr_pkg::VALUE_W-1:0] m_read_value,
    output logic [CNT_W-1:0]                    m_entry_count,
    output logic                                m_is_empty,
    output logic                                m_is_full
);
    import ubsr_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic               done_valid;
    logic               done_ready;
    res_t               done_res;
    logic [CNT_W-1:0]   done_count;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [VALUE_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [VALUE_W-1:0] mem_rd_data;

    logic               m_valid_reg;
    res_t               res_reg;
    logic [CNT_W-1:0]   count_out_reg;

    ubsr_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CNT_W    (CNT_W)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_value      (s_value),
        .s_slot_index (s_slot_index),
        .done_valid   (done_valid),
        .done_ready   (done_ready),
        .done_res     (done_res),
        .done_count   (done_count),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    ubsr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register frees the sequencer as soon as the result is parked
    assign done_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_ready) begin
            m_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_valid && done_ready) begin
            res_reg       <= done_res;
            count_out_reg <= done_count;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = res_reg.status;
    assign m_found       = res_reg.found;
    assign m_read_value  = res_reg.read_value;
    assign m_entry_count = count_out_reg;
    assign m_is_empty    = count_out_reg == '0;
    assign m_is_full     = count_out_reg == CNT_W'(CAPACITY);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entry_count <= CNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_status == ST_OK))
        else $error("found flag with error status");

    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> m_is_full)
        else $error("add rejected while bag not full");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in progress");

endmodule

FILE: design/ubsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubsr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ubsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/ubsr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubsr_seq
// Request sequencer: holds the entry count, drives the entry memory and
// walks it one entry per cycle for remove and member requests.
// ----------------------------------------------------------------------------
module ubsr_seq #(
    parameter int CAPACITY = 16,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ubsr_pkg::MODE_W-1:0]    s_mode,
    input  logic [ubsr_pkg::VALUE_W-1:0]   s_value,
    input  logic [ubsr_pkg::IDX_W-1:0]     s_slot_index,
    output logic                           done_valid,
    input  logic                           done_ready,
    output ubsr_pkg::res_t                 done_res,
    output logic [CNT_W-1:0]               done_count,
    output logic                           mem_wr_en,
    output logic [AW-1:0]                  mem_wr_addr,
    output logic [ubsr_pkg::VALUE_W-1:0]   mem_wr_data,
    output logic                           mem_rd_en,
    output logic [AW-1:0]                  mem_rd_addr,
    input  logic [ubsr_pkg::VALUE_W-1:0]   mem_rd_data
);
    import ubsr_pkg::*;

    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    seq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    mode_t              mode_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      pos_reg;
    status_t            status_reg;
    logic               found_reg;
    logic [VALUE_W-1:0] rdata_reg;

    logic               accept;
    mode_t              s_mode_e;
    logic               idx_ok;
    logic               not_full;
    logic               is_zero;
    logic               hit;
    logic [CNT_W-1:0]   ptr_inc;
    logic               ptr_more;
    logic [AW-1:0]      idx_addr;
    logic [AW-1:0]      last_addr;

    assign s_mode_e  = mode_t'(s_mode);
    assign accept    = s_valid && s_ready;
    assign idx_ok    = CMP_W'(s_slot_index) < CMP_W'(count_reg);
    assign not_full  = count_reg != CNT_W'(CAPACITY);
    assign is_zero   = count_reg == '0;
    assign hit       = mem_rd_data == value_reg;
    assign ptr_inc   = CNT_W'(ptr_reg) + CNT_W'(1);
    assign ptr_more  = ptr_inc < count_reg;
    assign idx_addr  = AW'(s_slot_index);
    assign last_addr = AW'(count_reg - CNT_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_mode_e)
                        MODE_REMOVE, MODE_MEMBER: state_next = is_zero ? S_DONE : S_SCAN;
                        MODE_READ:                state_next = idx_ok ? S_RDATA : S_DONE;
                        default:                  state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    state_next = (mode_reg == MODE_REMOVE) ? S_LAST : S_DONE;
                end else if (!ptr_more) begin
                    state_next = S_DONE;
                end
            end
            S_LAST:  state_next = S_DONE;
            S_RDATA: state_next = S_DONE;
            S_DONE: begin
                if (done_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        s_ready     = 1'b0;
        done_valid  = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = s_value;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        case (state_reg)
            S_IDLE: begin
                // no transfer while reset is held
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    case (s_mode_e)
                        MODE_ADD: begin
                            mem_wr_en   = not_full;
                            mem_wr_addr = AW'(count_reg);
                        end
                        MODE_WRITE: begin
                            mem_wr_en   = idx_ok;
                            mem_wr_addr = idx_addr;
                        end
                        MODE_READ: begin
                            mem_rd_en   = idx_ok;
                            mem_rd_addr = idx_addr;
                        end
                        MODE_REMOVE, MODE_MEMBER: begin
                            mem_rd_en = !is_zero;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    // on a remove hit, fetch the last entry to fill the hole
                    mem_rd_en   = mode_reg == MODE_REMOVE;
                    mem_rd_addr = last_addr;
                end else begin
                    mem_rd_en   = ptr_more;
                    mem_rd_addr = AW'(ptr_inc);
                end
            end
            S_LAST: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_reg;
                mem_wr_data = mem_rd_data;
            end
            S_DONE:  done_valid = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (accept && s_mode_e == MODE_ADD && not_full) begin
            count_next = count_reg + CNT_W'(1);
        end else if (state_reg == S_LAST) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg   <= s_mode_e;
            value_reg  <= s_value;
            ptr_reg    <= '0;
            found_reg  <= 1'b0;
            rdata_reg  <= '0;
            case (s_mode_e)
                MODE_ADD:                 status_reg <= not_full ? ST_OK : ST_FULL;
                MODE_REMOVE, MODE_MEMBER: status_reg <= is_zero ? ST_NOT_FOUND : ST_OK;
                MODE_READ, MODE_WRITE:    status_reg <= idx_ok ? ST_OK : ST_RANGE;
                default:                  status_reg <= ST_OK;
            endcase
        end else if (state_reg == S_SCAN) begin
            if (hit) begin
                found_reg <= 1'b1;
                pos_reg   <= ptr_reg;
            end else if (ptr_more) begin
                ptr_reg <= AW'(ptr_inc);
            end else begin
                status_reg <= ST_NOT_FOUND;
            end
        end else if (state_reg == S_RDATA) begin
            rdata_reg <= mem_rd_data;
        end
    end

    assign done_res.status     = status_reg;
    assign done_res.found      = found_reg;
    assign done_res.read_value = rdata_reg;
    assign done_count          = count_reg;

endmodule
